/* design/pier_pkg.sv */
// pier_pkg: shared types and constants for the pad input edge/repeat block
// used by pad_input_edge_repeat_top; depends on nothing else
`default_nettype none

package pier_pkg;

    // number of controller ports kept in state
    localparam int PORTS  = 4;
    localparam int PIDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;

    // field widths
    localparam int BTN_W  = 16;
    localparam int AXIS_W = 8;
    localparam int DIR_W  = 4;
    localparam int HOLD_W = 16;
    localparam int CNT_W  = 16;   // live reports in one frame
    localparam int SUM_W  = 24;   // stick sum over one frame
    localparam int DVD_W  = 24;   // dividend of the shared divide unit
    localparam int STEP_W = 5;    // divide step counter

    // divide lengths in steps
    localparam logic [STEP_W-1:0] MOD_STEPS = STEP_W'(HOLD_W);
    localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(DVD_W);

    // source code of the combined result
    localparam logic [2:0] SHARED_SOURCE = 3'd4;

    // port status codes
    localparam logic [1:0] STAT_LIVE = 2'd0;
    localparam logic [1:0] STAT_LOST = 2'd1;
    localparam logic [1:0] STAT_DEAD = 2'd2;

    // direction bits
    localparam int DIR_LEFT  = 0;
    localparam int DIR_RIGHT = 1;
    localparam int DIR_DOWN  = 2;
    localparam int DIR_UP    = 3;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_REPEAT_DELAY    = 2'd0,
        CFG_REPEAT_PERIOD   = 2'd1,
        CFG_STICK_THRESHOLD = 2'd2,
        CFG_BUTTON_MASK     = 2'd3
    } t_cfg_reg;

    // configuration reset values
    localparam logic [15:0] RST_REPEAT_DELAY    = 16'd15;
    localparam logic [15:0] RST_REPEAT_PERIOD   = 16'd5;
    localparam logic [6:0]  RST_STICK_THRESHOLD = 7'd50;
    localparam logic [15:0] RST_BUTTON_MASK     = 16'hFFFF;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MOD,
        ST_PRES,
        ST_DIVX,
        ST_DIVY,
        ST_SRES
    } t_state;

    // control strobes from the sequencer to the datapath
    typedef struct packed {
        logic accept;
        logic eval;
        logic mod_load;
        logic mod_step;
        logic load_port;
        logic divx_load;
        logic divx_step;
        logic divy_step;
        logic load_shared;
    } t_ctrl;

endpackage

`default_nettype wire

/* design/pad_input_edge_repeat_top.sv */
// pad_input_edge_repeat_top: per-port button/stick edge detection with auto-repeat
// and a combined shared result per poll frame; depends on pier_pkg
// a port result is evaluated into the result registers and, when the repeat phase
//   has to be checked, a remainder is taken on the shared divide unit before the output load
// the shared result follows after two divides (x and y stick averages) and its load
//   when a port was live in the frame, else it is loaded once the port result is taken
// one report at a time: o_stall stays high until the block is back in idle
// reset (synchronous, active low) restores config defaults and clears all port state
`default_nettype none

module pad_input_edge_repeat_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // configuration writes
    input  wire                                 i_cfg_we,
    input  wire [1:0]                           i_cfg_idx,
    input  wire [15:0]                          i_cfg_wdata,
    // report channel
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire [1:0]                           i_port,
    input  wire                                 i_pad_error,
    input  wire [pier_pkg::BTN_W-1:0]           i_raw_buttons,
    input  wire signed [pier_pkg::AXIS_W-1:0]   i_axis_x,
    input  wire signed [pier_pkg::AXIS_W-1:0]   i_axis_y,
    input  wire                                 i_frame_end,
    // result channel
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic [2:0]                          o_source,
    output logic [1:0]                          o_port_status,
    output logic [pier_pkg::BTN_W-1:0]          o_held_buttons,
    output logic [pier_pkg::BTN_W-1:0]          o_pressed_buttons,
    output logic [pier_pkg::BTN_W-1:0]          o_released_buttons,
    output logic signed [pier_pkg::AXIS_W-1:0]  o_stick_x_out,
    output logic signed [pier_pkg::AXIS_W-1:0]  o_stick_y_out,
    output logic [pier_pkg::DIR_W-1:0]          o_direction_now,
    output logic [pier_pkg::DIR_W-1:0]          o_direction_pressed,
    output logic [pier_pkg::DIR_W-1:0]          o_direction_released,
    output logic                                o_repeat_pulse,
    output logic                                o_last
);

    import pier_pkg::*;

    // configuration registers
    logic [15:0] r_repeat_delay;
    logic [15:0] r_repeat_period;
    logic [6:0]  r_stick_threshold;
    logic [15:0] r_button_mask;

    // sequencer
    t_state r_state, n_state;
    t_ctrl  ctrl;

    // captured report
    logic [1:0]              r_port;
    logic                    r_err;
    logic [BTN_W-1:0]        r_raw;
    logic signed [AXIS_W-1:0] r_ax, r_ay;
    logic                    r_fend;

    // per-port state
    logic [PORTS-1:0]        r_dead;
    logic [BTN_W-1:0]        r_prev_btn  [PORTS];
    logic [DIR_W-1:0]        r_prev_dir  [PORTS];
    logic [HOLD_W-1:0]       r_hold      [PORTS];
    logic [2*AXIS_W-1:0]     r_last_axes [PORTS];

    // frame accumulators
    logic [BTN_W-1:0]        r_acc_held, r_acc_pressed, r_acc_released;
    logic [DIR_W-1:0]        r_acc_dnow, r_acc_dpressed, r_acc_dreleased;
    logic                    r_acc_pulse;
    logic signed [SUM_W-1:0] r_sum_x, r_sum_y;
    logic [CNT_W-1:0]        r_live_cnt;
    logic signed [AXIS_W-1:0] r_shared_x, r_shared_y;

    // port result waiting for the output register
    logic [1:0]              r_res_status;
    logic [BTN_W-1:0]        r_res_held, r_res_pressed, r_res_released;
    logic [DIR_W-1:0]        r_res_dnow, r_res_dpressed, r_res_dreleased;
    logic                    r_res_pulse;

    // shared divide unit
    logic [DVD_W-1:0]        r_dvd;
    logic [CNT_W-1:0]        r_dsr;
    logic [CNT_W-1:0]        r_rem;
    logic [AXIS_W-1:0]       r_quo;
    logic [STEP_W-1:0]       r_cnt;
    logic                    r_neg;
    logic signed [AXIS_W-1:0] r_qx;

    // output register
    logic                    r_ovalid;
    logic                    out_free;

    // ---------------------------------------------------------------
    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_delay    <= RST_REPEAT_DELAY;
            r_repeat_period   <= RST_REPEAT_PERIOD;
            r_stick_threshold <= RST_STICK_THRESHOLD;
            r_button_mask     <= RST_BUTTON_MASK;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_REPEAT_DELAY:    r_repeat_delay    <= i_cfg_wdata;
                CFG_REPEAT_PERIOD:   r_repeat_period   <= i_cfg_wdata;
                CFG_STICK_THRESHOLD: r_stick_threshold <= i_cfg_wdata[6:0];
                CFG_BUTTON_MASK:     r_button_mask     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // evaluation of the captured report against its port state
    logic [PIDX_W-1:0]  pidx;
    logic               in_range, live, good;
    logic [BTN_W-1:0]   cur, prv, bd;
    logic [DIR_W-1:0]   dcur, dprv, dd;
    logic signed [AXIS_W:0] thr_pos, thr_neg, ax_w, ay_w;
    logic               same_held;
    logic [HOLD_W-1:0]  hold_n;
    logic               mod_needed;
    logic [HOLD_W-1:0]  per_eff;

    always_comb begin
        pidx     = PIDX_W'(r_port);
        in_range = (32'(r_port) < PORTS);
        live     = in_range && !r_dead[pidx];
        good     = live && !r_err;

        cur = r_raw & r_button_mask;
        prv = r_prev_btn[pidx];
        bd  = prv ^ cur;

        // stick quantizer, left and down win by test order
        thr_pos = (AXIS_W+1)'({1'b0, r_stick_threshold});
        thr_neg = -thr_pos;
        ax_w    = (AXIS_W+1)'(r_ax);
        ay_w    = (AXIS_W+1)'(r_ay);
        dcur    = '0;
        if (ax_w < thr_neg) begin
            dcur[DIR_LEFT] = 1'b1;
        end else if (ax_w > thr_pos) begin
            dcur[DIR_RIGHT] = 1'b1;
        end
        if (ay_w < thr_neg) begin
            dcur[DIR_DOWN] = 1'b1;
        end else if (ay_w > thr_pos) begin
            dcur[DIR_UP] = 1'b1;
        end
        dprv = r_prev_dir[pidx];
        dd   = dprv ^ dcur;

        // hold counter with saturation
        same_held = ((cur != '0) || (dcur != '0)) && (cur == prv) && (dcur == dprv);
        if (!same_held) begin
            hold_n = '0;
        end else if (r_hold[pidx] == '1) begin
            hold_n = r_hold[pidx];
        end else begin
            hold_n = r_hold[pidx] + HOLD_W'(1);
        end
        mod_needed = good && same_held && (hold_n >= r_repeat_delay);
        per_eff    = (r_repeat_period == '0) ? HOLD_W'(1) : r_repeat_period;
    end

    // ---------------------------------------------------------------
    // shared divide unit: one restoring step per cycle
    logic [CNT_W:0]   trial;
    logic             ge;
    logic [CNT_W-1:0] rem_n;
    logic [AXIS_W-1:0] quo_n;
    logic             step_last;
    logic [SUM_W-1:0] mag_x, mag_y;

    always_comb begin
        trial     = {r_rem, r_dvd[DVD_W-1]};
        ge        = (trial >= {1'b0, r_dsr});
        rem_n     = ge ? CNT_W'(trial - {1'b0, r_dsr}) : CNT_W'(trial);
        quo_n     = {r_quo[AXIS_W-2:0], ge};
        step_last = (r_cnt == STEP_W'(1));
        mag_x     = r_sum_x[SUM_W-1] ? SUM_W'(-r_sum_x) : SUM_W'(r_sum_x);
        mag_y     = r_sum_y[SUM_W-1] ? SUM_W'(-r_sum_y) : SUM_W'(r_sum_y);
    end

    // ---------------------------------------------------------------
    // sequencer: next state
    assign out_free = !r_ovalid || !i_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_EVAL;
            ST_EVAL: n_state = mod_needed ? ST_MOD : ST_PRES;
            ST_MOD:  if (step_last) n_state = ST_PRES;
            ST_PRES: begin
                if (out_free) begin
                    if (!r_fend) begin
                        n_state = ST_IDLE;
                    end else if (r_live_cnt != '0) begin
                        n_state = ST_DIVX;
                    end else begin
                        n_state = ST_SRES;
                    end
                end
            end
            ST_DIVX: if (step_last) n_state = ST_DIVY;
            ST_DIVY: if (step_last) n_state = ST_SRES;
            ST_SRES: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer: control strobes
    always_comb begin
        ctrl = '0;
        unique case (r_state)
            ST_IDLE: ctrl.accept = i_valid;
            ST_EVAL: begin
                ctrl.eval     = 1'b1;
                ctrl.mod_load = mod_needed;
            end
            ST_MOD:  ctrl.mod_step = 1'b1;
            ST_PRES: begin
                ctrl.load_port = out_free;
                ctrl.divx_load = out_free && r_fend && (r_live_cnt != '0);
            end
            ST_DIVX: ctrl.divx_step = 1'b1;
            ST_DIVY: ctrl.divy_step = 1'b1;
            ST_SRES: ctrl.load_shared = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != ST_IDLE);

    // ---------------------------------------------------------------
    // report capture
    always_ff @(posedge i_clk) begin
        if (ctrl.accept) begin
            r_port <= i_port;
            r_err  <= i_pad_error;
            r_raw  <= i_raw_buttons;
            r_ax   <= i_axis_x;
            r_ay   <= i_axis_y;
            r_fend <= i_frame_end;
        end
    end

    // ---------------------------------------------------------------
    // per-port state and frame accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead          <= '0;
            r_acc_held      <= '0;
            r_acc_pressed   <= '0;
            r_acc_released  <= '0;
            r_acc_dnow      <= '0;
            r_acc_dpressed  <= '0;
            r_acc_dreleased <= '0;
            r_acc_pulse     <= 1'b0;
            r_sum_x         <= '0;
            r_sum_y         <= '0;
            r_live_cnt      <= '0;
            r_shared_x      <= '0;
            r_shared_y      <= '0;
            for (int i = 0; i < PORTS; i++) begin
                r_prev_btn[i]  <= '0;
                r_prev_dir[i]  <= '0;
                r_hold[i]      <= '0;
                r_last_axes[i] <= '0;
            end
        end else begin
            // an error on a live port marks it dead; a good report updates its port and the frame
            if (ctrl.eval && live && r_err) begin
                r_dead[pidx] <= 1'b1;
            end
            if (ctrl.eval && good) begin
                r_prev_btn[pidx]  <= cur;
                r_prev_dir[pidx]  <= dcur;
                r_hold[pidx]      <= hold_n;
                r_last_axes[pidx] <= {r_ax, r_ay};
                r_acc_held        <= r_acc_held | cur;
                r_acc_pressed     <= r_acc_pressed | (bd & cur);
                r_acc_released    <= r_acc_released | (bd & prv);
                r_acc_dnow        <= r_acc_dnow | dcur;
                r_acc_dpressed    <= r_acc_dpressed | (dd & dcur);
                r_acc_dreleased   <= r_acc_dreleased | (dd & dprv);
                r_sum_x           <= r_sum_x + SUM_W'(r_ax);
                r_sum_y           <= r_sum_y + SUM_W'(r_ay);
                r_live_cnt        <= r_live_cnt + CNT_W'(1);
            end
            // repeat phase found on the last remainder step
            if (ctrl.mod_step && step_last && (rem_n == '0)) begin
                r_acc_pulse <= 1'b1;
            end
            // new stick average once both quotients are done
            if (ctrl.divy_step && step_last) begin
                r_shared_x <= r_qx;
                r_shared_y <= r_neg ? AXIS_W'(-quo_n) : quo_n;
            end
            // frame closes as the shared result goes out
            if (ctrl.load_shared) begin
                r_acc_held      <= '0;
                r_acc_pressed   <= '0;
                r_acc_released  <= '0;
                r_acc_dnow      <= '0;
                r_acc_dpressed  <= '0;
                r_acc_dreleased <= '0;
                r_acc_pulse     <= 1'b0;
                r_sum_x         <= '0;
                r_sum_y         <= '0;
                r_live_cnt      <= '0;
            end
        end
    end

    // ---------------------------------------------------------------
    // port result held until the output register is free
    always_ff @(posedge i_clk) begin
        if (ctrl.eval) begin
            r_res_status    <= !in_range || !live ? STAT_DEAD
                             : (r_err ? STAT_LOST : STAT_LIVE);
            r_res_held      <= good ? cur : '0;
            r_res_pressed   <= good ? (bd & cur) : '0;
            r_res_released  <= good ? (bd & prv) : '0;
            r_res_dnow      <= good ? dcur : '0;
            r_res_dpressed  <= good ? (dd & dcur) : '0;
            r_res_dreleased <= good ? (dd & dprv) : '0;
            r_res_pulse     <= 1'b0;
        end else if (ctrl.mod_step && step_last) begin
            r_res_pulse <= (rem_n == '0);
        end
    end

    // ---------------------------------------------------------------
    // divide unit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (ctrl.mod_load) begin
            r_dvd <= {hold_n - r_repeat_delay, {(DVD_W-HOLD_W){1'b0}}};
            r_dsr <= CNT_W'(per_eff);
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= MOD_STEPS;
        end else if (ctrl.divx_load) begin
            r_dvd <= DVD_W'(mag_x);
            r_dsr <= r_live_cnt;
            r_rem <= '0;
            r_quo <= '0;
            r_neg <= r_sum_x[SUM_W-1];
            r_cnt <= DIV_STEPS;
        end else if (ctrl.divx_step && step_last) begin
            // x done, start y
            r_qx  <= r_neg ? AXIS_W'(-quo_n) : quo_n;
            r_dvd <= DVD_W'(mag_y);
            r_rem <= '0;
            r_quo <= '0;
            r_neg <= r_sum_y[SUM_W-1];
            r_cnt <= DIV_STEPS;
        end else if (ctrl.mod_step || ctrl.divx_step || ctrl.divy_step) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= rem_n;
            r_quo <= quo_n;
            r_cnt <= r_cnt - STEP_W'(1);
        end
    end

    // ---------------------------------------------------------------
    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (ctrl.load_port || ctrl.load_shared) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.load_port) begin
            o_source             <= {1'b0, r_port};
            o_port_status        <= r_res_status;
            o_held_buttons       <= r_res_held;
            o_pressed_buttons    <= r_res_pressed;
            o_released_buttons   <= r_res_released;
            o_stick_x_out        <= (r_res_status == STAT_LIVE) ? r_ax : '0;
            o_stick_y_out        <= (r_res_status == STAT_LIVE) ? r_ay : '0;
            o_direction_now      <= r_res_dnow;
            o_direction_pressed  <= r_res_dpressed;
            o_direction_released <= r_res_dreleased;
            o_repeat_pulse       <= r_res_pulse;
            o_last               <= !r_fend;
        end else if (ctrl.load_shared) begin
            o_source             <= SHARED_SOURCE;
            o_port_status        <= STAT_LIVE;
            o_held_buttons       <= r_acc_held;
            o_pressed_buttons    <= r_acc_pressed;
            o_released_buttons   <= r_acc_released;
            o_stick_x_out        <= r_shared_x;
            o_stick_y_out        <= r_shared_y;
            o_direction_now      <= r_acc_dnow;
            o_direction_pressed  <= r_acc_dpressed;
            o_direction_released <= r_acc_dreleased;
            o_repeat_pulse       <= r_acc_pulse;
            o_last               <= 1'b1;
        end
    end

    assign o_valid = r_ovalid;

    // ---------------------------------------------------------------
    // assertions
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("report taken without blocking the next one");

    a_shared_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_source == SHARED_SOURCE) |-> (o_last && o_port_status == STAT_LIVE))
        else $error("shared result not marked as final");

    a_nonlive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_port_status != STAT_LIVE) |->
        (o_held_buttons == '0 && o_direction_now == '0 && !o_repeat_pulse))
        else $error("lost or dead port carries data");

    a_pulse_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_source != SHARED_SOURCE && o_repeat_pulse) |->
        (o_held_buttons != '0 || o_direction_now != '0))
        else $error("repeat pulse with nothing held");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !(ctrl.load_port || ctrl.load_shared))
        else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

/* tb/sv/pad_input_edge_repeat_top_test.sv */
// self-checking testbench for pad_input_edge_repeat_top: directed and random pad reports
// with an in-order predictor of port and shared results, random idling on both sides
// depends on pier_pkg and the design under design/
`timescale 1ns / 1ps

module pad_input_edge_repeat_top_test;

    import pier_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int DRAIN_PAUSE = 80;       // covers the two shared divides and some margin
    localparam int HOLD_MAX    = 65535;

    // one report as sent to the block
    typedef struct {
        logic [1:0]        port;
        logic              pad_error;
        logic [15:0]       raw_buttons;
        logic signed [7:0] axis_x;
        logic signed [7:0] axis_y;
        logic              frame_end;
    } pad_report_t;

    // one result as expected from the block
    typedef struct {
        logic [2:0]        source;
        logic [1:0]        status;
        logic [15:0]       held;
        logic [15:0]       pressed;
        logic [15:0]       released;
        logic signed [7:0] stick_x;
        logic signed [7:0] stick_y;
        logic [3:0]        dir_now;
        logic [3:0]        dir_pressed;
        logic [3:0]        dir_released;
        logic              pulse;
        logic              is_last;
    } pad_result_t;

    // dut ports
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_idx = '0;
    logic [15:0]       i_cfg_wdata = '0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [1:0]        i_port = '0;
    logic              i_pad_error = 1'b0;
    logic [15:0]       i_raw_buttons = '0;
    logic signed [7:0] i_axis_x = '0;
    logic signed [7:0] i_axis_y = '0;
    logic              i_frame_end = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [2:0]        o_source;
    logic [1:0]        o_port_status;
    logic [15:0]       o_held_buttons;
    logic [15:0]       o_pressed_buttons;
    logic [15:0]       o_released_buttons;
    logic signed [7:0] o_stick_x_out;
    logic signed [7:0] o_stick_y_out;
    logic [3:0]        o_direction_now;
    logic [3:0]        o_direction_pressed;
    logic [3:0]        o_direction_released;
    logic              o_repeat_pulse;
    logic              o_last;

    // predictor copy of the registers
    int cfg_delay  = int'(RST_REPEAT_DELAY);
    int cfg_period = int'(RST_REPEAT_PERIOD);
    int cfg_thresh = int'(RST_STICK_THRESHOLD);
    int cfg_mask   = int'(RST_BUTTON_MASK);

    // predictor copy of the per-port and per-frame state
    logic        dead_port [PORTS] = '{default: 1'b0};
    logic [15:0] prev_btn  [PORTS] = '{default: '0};
    logic [3:0]  prev_dir  [PORTS] = '{default: '0};
    int          hold_cnt  [PORTS] = '{default: 0};
    logic [15:0] acc_held = '0, acc_pressed = '0, acc_released = '0;
    logic [3:0]  acc_dir_now = '0, acc_dir_pressed = '0, acc_dir_released = '0;
    logic        acc_pulse = 1'b0;
    int          sum_x = 0, sum_y = 0, live_cnt = 0;
    logic signed [7:0] shared_x = '0, shared_y = '0;

    pad_result_t pending_results [$];

    // random pad held per port in the random frames
    logic [15:0]       rnd_btn [PORTS] = '{default: '0};
    logic signed [7:0] rnd_x   [PORTS] = '{default: '0};
    logic signed [7:0] rnd_y   [PORTS] = '{default: '0};

    int idle_pct  = 30;
    int stall_pct = 30;
    int mismatch_count = 0;
    int cycle_count = 0;

    pad_input_edge_repeat_top uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_port               (i_port),
        .i_pad_error          (i_pad_error),
        .i_raw_buttons        (i_raw_buttons),
        .i_axis_x             (i_axis_x),
        .i_axis_y             (i_axis_y),
        .i_frame_end          (i_frame_end),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_source             (o_source),
        .o_port_status        (o_port_status),
        .o_held_buttons       (o_held_buttons),
        .o_pressed_buttons    (o_pressed_buttons),
        .o_released_buttons   (o_released_buttons),
        .o_stick_x_out        (o_stick_x_out),
        .o_stick_y_out        (o_stick_y_out),
        .o_direction_now      (o_direction_now),
        .o_direction_pressed  (o_direction_pressed),
        .o_direction_released (o_direction_released),
        .o_repeat_pulse       (o_repeat_pulse),
        .o_last               (o_last)
    );

    // clock
    always #4 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // gap length: none with chance 100-pct percent, else mostly short, a few long
    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(12, 40);
        return $urandom_range(1, 3);
    endfunction

    // result-side stall bursts
    always @(posedge i_clk) begin
        int stall_left;
        int run;
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            run = pick_gap(stall_pct);
            if (run > 0) begin
                stall_left = run - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // four direction bits from the stick against the threshold
    function automatic logic [3:0] stick_direction(input int x, input int y);
        logic [3:0] d;
        d = '0;
        if (x < -cfg_thresh)
            d[DIR_LEFT] = 1'b1;
        else if (x > cfg_thresh)
            d[DIR_RIGHT] = 1'b1;
        if (y < -cfg_thresh)
            d[DIR_DOWN] = 1'b1;
        else if (y > cfg_thresh)
            d[DIR_UP] = 1'b1;
        return d;
    endfunction

    // expected port result, and shared result at frame end, for one accepted report
    function automatic void compute_pad_results(input pad_report_t r);
        pad_result_t res;
        pad_result_t shr;
        logic [15:0] cur, prv, bd;
        logic [3:0]  dcur, dprv, dd;
        int          x, y, per, ax, ay, p;
        res = '{default: '0};
        p = int'(r.port);
        res.source = {1'b0, r.port};
        if (p >= PORTS || dead_port[p]) begin
            res.status = STAT_DEAD;
        end else if (r.pad_error) begin
            dead_port[p] = 1'b1;
            res.status = STAT_LOST;
        end else begin
            x = r.axis_x;
            y = r.axis_y;
            cur = r.raw_buttons & cfg_mask[15:0];
            prv = prev_btn[p];
            bd = cur ^ prv;
            dcur = stick_direction(x, y);
            dprv = prev_dir[p];
            dd = dcur ^ dprv;
            res.status = STAT_LIVE;
            // hold counting and repeat phase
            if ((cur != 0 || dcur != 0) && cur == prv && dcur == dprv) begin
                per = (cfg_period == 0) ? 1 : cfg_period;
                if (hold_cnt[p] < HOLD_MAX)
                    hold_cnt[p]++;
                if (hold_cnt[p] >= cfg_delay && (hold_cnt[p] - cfg_delay) % per == 0)
                    res.pulse = 1'b1;
            end else begin
                hold_cnt[p] = 0;
            end
            prev_btn[p] = cur;
            prev_dir[p] = dcur;
            res.held = cur;
            res.pressed = bd & cur;
            res.released = bd & prv;
            res.stick_x = r.axis_x;
            res.stick_y = r.axis_y;
            res.dir_now = dcur;
            res.dir_pressed = dd & dcur;
            res.dir_released = dd & dprv;
            // frame accumulation
            acc_held |= res.held;
            acc_pressed |= res.pressed;
            acc_released |= res.released;
            acc_dir_now |= res.dir_now;
            acc_dir_pressed |= res.dir_pressed;
            acc_dir_released |= res.dir_released;
            acc_pulse |= res.pulse;
            sum_x += x;
            sum_y += y;
            live_cnt++;
        end
        res.is_last = !r.frame_end;
        pending_results.push_back(res);

        if (r.frame_end) begin
            // average kept from an earlier frame when nothing was live
            if (live_cnt != 0) begin
                ax = sum_x / live_cnt;
                ay = sum_y / live_cnt;
                shared_x = ax[7:0];
                shared_y = ay[7:0];
            end
            shr = '{default: '0};
            shr.source = SHARED_SOURCE;
            shr.status = STAT_LIVE;
            shr.held = acc_held;
            shr.pressed = acc_pressed;
            shr.released = acc_released;
            shr.stick_x = shared_x;
            shr.stick_y = shared_y;
            shr.dir_now = acc_dir_now;
            shr.dir_pressed = acc_dir_pressed;
            shr.dir_released = acc_dir_released;
            shr.pulse = acc_pulse;
            shr.is_last = 1'b1;
            pending_results.push_back(shr);
            acc_held = '0;
            acc_pressed = '0;
            acc_released = '0;
            acc_dir_now = '0;
            acc_dir_pressed = '0;
            acc_dir_released = '0;
            acc_pulse = 1'b0;
            sum_x = 0;
            sum_y = 0;
            live_cnt = 0;
        end
    endfunction

    function automatic void note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endfunction

    function automatic void check_field(input string what, input int want, input int got);
        if (want != got)
            note_failure($sformatf("%s expected %0d actual %0d", what, want, got));
    endfunction

    // result checking on every transfer
    always @(posedge i_clk) begin
        pad_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected result from source %0d", o_source));
            end else begin
                want = pending_results.pop_front();
                check_field("source", want.source, o_source);
                check_field("port_status", want.status, o_port_status);
                check_field("held_buttons", want.held, o_held_buttons);
                check_field("pressed_buttons", want.pressed, o_pressed_buttons);
                check_field("released_buttons", want.released, o_released_buttons);
                check_field("stick_x_out", want.stick_x, o_stick_x_out);
                check_field("stick_y_out", want.stick_y, o_stick_y_out);
                check_field("direction_now", want.dir_now, o_direction_now);
                check_field("direction_pressed", want.dir_pressed, o_direction_pressed);
                check_field("direction_released", want.dir_released, o_direction_released);
                check_field("repeat_pulse", want.pulse, o_repeat_pulse);
                check_field("last", want.is_last, o_last);
            end
        end
    end

    function automatic pad_report_t make_report(input int port, input int err, input int btn,
                                                input int x, input int y, input int fend);
        pad_report_t r;
        r.port = port[1:0];
        r.pad_error = err[0];
        r.raw_buttons = btn[15:0];
        r.axis_x = x[7:0];
        r.axis_y = y[7:0];
        r.frame_end = fend[0];
        return r;
    endfunction

    // one report transfer; valid stays up when the next report follows at once
    task automatic send_report(input pad_report_t r);
        int gap;
        gap = pick_gap(idle_pct);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_port <= r.port;
        i_pad_error <= r.pad_error;
        i_raw_buttons <= r.raw_buttons;
        i_axis_x <= r.axis_x;
        i_axis_y <= r.axis_y;
        i_frame_end <= r.frame_end;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        compute_pad_results(r);
    endtask

    // hold off until every expected result has come, then let the block settle
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    // write all four registers while the block is idle
    task automatic apply_config(input int delay, input int period, input int thresh,
                                input int mask);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_REPEAT_DELAY;
        i_cfg_wdata <= delay[15:0];
        @(posedge i_clk);
        i_cfg_idx <= CFG_REPEAT_PERIOD;
        i_cfg_wdata <= period[15:0];
        @(posedge i_clk);
        i_cfg_idx <= CFG_STICK_THRESHOLD;
        i_cfg_wdata <= thresh[15:0];
        @(posedge i_clk);
        i_cfg_idx <= CFG_BUTTON_MASK;
        i_cfg_wdata <= mask[15:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_delay = delay & 16'hFFFF;
        cfg_period = period & 16'hFFFF;
        cfg_thresh = thresh & 7'h7F;
        cfg_mask = mask & 16'hFFFF;
    endtask

    // stick sample near the threshold, at the extremes, at zero or at random
    function automatic logic signed [7:0] pick_axis();
        int v;
        case ($urandom_range(7))
            0: v = -128;
            1: v = 127;
            2: v = 0;
            3: v = -cfg_thresh - 1;
            4: v = -cfg_thresh;
            5: v = cfg_thresh;
            6: v = cfg_thresh + 1;
            default: v = int'($urandom_range(255)) - 128;
        endcase
        if (v > 127)
            v = 127;
        if (v < -128)
            v = -128;
        return v[7:0];
    endfunction

    // field extremes, edges both ways, threshold boundaries, truncating average
    task automatic test_directed_edges();
        send_report(make_report(0, 0, 16'hFFFF, 127, -128, 0));
        send_report(make_report(1, 0, 16'h0000, -128, 127, 0));
        send_report(make_report(2, 0, 16'h5A5A, 50, -50, 0));
        send_report(make_report(3, 0, 16'hA5A5, 51, -51, 1));
        send_report(make_report(0, 0, 16'h0000, 0, 0, 0));
        send_report(make_report(1, 0, 16'h8001, -51, 51, 1));
    endtask

    // repeat pulses: period zero, idle inputs never held, stick-only hold
    task automatic test_repeat_timing();
        int k;
        apply_config(3, 0, 50, 16'hFFFF);
        for (k = 0; k < 4; k++)
            send_report(make_report(1, 0, 16'h8001, -51, 51, 0));
        send_report(make_report(1, 0, 16'h0000, 0, 0, 0));
        send_report(make_report(1, 0, 16'h0000, 0, 0, 1));
        apply_config(2, 3, 50, 16'hFFFF);
        for (k = 0; k < 6; k++)
            send_report(make_report(1, 0, 16'h0000, 0, -90, k == 5));
    endtask

    // button mask and both threshold extremes
    task automatic test_mask_threshold();
        apply_config(15, 5, 0, 16'h00F0);
        send_report(make_report(2, 0, 16'hFFFF, 1, -1, 0));
        apply_config(15, 5, 127, 16'hFFFF);
        send_report(make_report(2, 0, 16'hFFFF, -128, 127, 1));
    endtask

    // long hold: first pulse after the delay, then one every period
    task automatic test_long_hold();
        int k;
        idle_pct = 2;
        stall_pct = 2;
        apply_config(20, 7, 50, 16'hFFFF);
        for (k = 0; k < 40; k++)
            send_report(make_report(0, 0, 16'h0001, 0, 0, (k % 8) == 7));
    endtask

    // lost and dead ports, frames with nothing live
    task automatic test_port_loss();
        send_report(make_report(3, 1, 16'hFFFF, 127, 127, 0));
        send_report(make_report(3, 0, 16'h1234, -128, 0, 0));
        send_report(make_report(3, 1, 16'h0000, 0, 0, 1));
        send_report(make_report(2, 1, 16'hFFFF, 0, 0, 0));
        send_report(make_report(2, 0, 16'hFFFF, 5, 5, 1));
        send_report(make_report(0, 0, 16'h0F0F, 10, -10, 1));
    endtask

    // mostly whole frames with pads held for a while; some odd frames
    task automatic test_random_frames(input int n_items, input int err_pct);
        pad_report_t r;
        int sent;
        int n_rep;
        int k;
        int p;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(49) == 0)
                wait_drained();
            n_rep = ($urandom_range(9) < 8) ? PORTS : $urandom_range(1, 6);
            for (k = 0; k < n_rep; k++) begin
                p = (n_rep == PORTS) ? k : $urandom_range(PORTS - 1);
                // new pad contents now and then, otherwise held
                if ($urandom_range(99) < 20) begin
                    case ($urandom_range(4))
                        0: rnd_btn[p] = 16'($urandom);
                        1: rnd_btn[p] = rnd_btn[p] ^ (16'h1 << $urandom_range(15));
                        2: rnd_btn[p] = 16'h0000;
                        3: rnd_btn[p] = 16'hFFFF;
                        default: ;
                    endcase
                    if ($urandom_range(1) == 0) begin
                        rnd_x[p] = pick_axis();
                        rnd_y[p] = pick_axis();
                    end
                end
                r = make_report(p, $urandom_range(99) < err_pct, rnd_btn[p],
                                rnd_x[p], rnd_y[p], k == n_rep - 1);
                if ($urandom_range(19) == 0)
                    r.frame_end = ~r.frame_end;
                send_report(r);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_repeat_timing();
        test_mask_threshold();
        test_long_hold();

        idle_pct = 30;
        stall_pct = 30;
        apply_config(0, 0, 0, 16'hFFFF);
        test_random_frames(170, 0);

        // no idling on either side
        idle_pct = 0;
        stall_pct = 0;
        apply_config(65535, 65535, 127, 16'h0000);
        test_random_frames(80, 0);

        idle_pct = 50;
        stall_pct = 50;
        apply_config(2, 3, 50, 16'hF0F3);
        test_random_frames(170, 0);

        idle_pct = 20;
        stall_pct = 60;
        apply_config(1, 1, 100, 16'hFFFF);
        test_random_frames(170, 0);

        idle_pct = 40;
        stall_pct = 10;
        apply_config(int'(RST_REPEAT_DELAY), int'(RST_REPEAT_PERIOD),
                     int'(RST_STICK_THRESHOLD), int'(RST_BUTTON_MASK));
        test_random_frames(170, 0);

        test_port_loss();
        test_random_frames(60, 15);

        wait_drained();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
design/pier_pkg.sv
design/pad_input_edge_repeat_top.sv
tb/sv/pad_input_edge_repeat_top_test.sv
